// ===== rtl/core/dqu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dqu_pkg
// Shared types and codes for the bounded deque unit and its cells.
// ----------------------------------------------------------------------------
package dqu_pkg;

  localparam int DataW    = 32;
  localparam int CmdW     = 2;
  localparam int StatusW  = 2;
  localparam int OccW     = 5;
  localparam int CapW     = 5;
  localparam int DefDepth = 16;

  localparam logic [CapW-1:0] CapReset = CapW'(16);

  // Command codes
  localparam logic [CmdW-1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [CmdW-1:0] CMD_PUSH_REAR  = 2'd1;
  localparam logic [CmdW-1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [CmdW-1:0] CMD_POP_REAR   = 2'd3;

  // Status codes
  localparam logic [StatusW-1:0] ST_DONE      = 2'd0;
  localparam logic [StatusW-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [StatusW-1:0] ST_UNDERFLOW = 2'd2;

  // Value returned by a refused pop
  localparam logic [DataW-1:0] PopRefused = '1;

  // One-hot operation broadcast to every cell; all zero when idle or refused
  typedef struct packed {
    logic shift_r;   // push front: every entry moves one cell toward the rear
    logic shift_l;   // pop front: every entry moves one cell toward the front
    logic put_rear;  // push rear: first empty cell takes the word
    logic drop_rear; // pop rear: last occupied cell empties
  } ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/bounded_double_ended_queue_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_unit
// Bounded deque of signed 32-bit words built as a row of shifting cells.
// ----------------------------------------------------------------------------
//
//  channel  | direction | contents
//  ---------+-----------+--------------------------------------------------
//  s_axis   | in        | tuser: cmd; tdata: push_value
//  m_axis   | out       | tuser: status; tdata: pop_value, occupancy
//  cfg      | in        | capacity register write (5 bits)
//
//  One item per cycle: every operation is registered in the cell row on accept,
//  and the result lands in one output register, so an item is taken
//  whenever that register is empty or being drained in the same cycle.
//  The result is valid in the cycle after the item is accepted.
//  Reset clears the cell valid bits, the occupancy count and the output
//  valid, and sets capacity to 16; cell words need no clearing.
//  A stall on m_axis holds the result and stops s_axis from accepting.
//
//  Entries sit front-aligned: cell 0 holds the front entry, the cells up to
//  the count hold the rest in order. Front operations shift the whole row;
//  rear operations touch only the cell at the boundary of the valid bits.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_unit #(
  parameter int DEPTH = dqu_pkg::DefDepth
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // input items
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [dqu_pkg::DataW-1:0]   s_axis_tdata,  // [31:0] push_value
  input  wire logic [dqu_pkg::CmdW-1:0]    s_axis_tuser,  // [1:0] cmd
  // result items
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic      [39:0]                 m_axis_tdata,  // [31:0] pop_value,
                                                          // [36:32] occupancy,
                                                          // [39:37] zero
  output logic      [dqu_pkg::StatusW-1:0] m_axis_tuser,  // [1:0] status
  // capacity register
  input  wire logic                        cfg_we_i,
  input  wire logic [dqu_pkg::CapW-1:0]    cfg_wdata_i
);
  import dqu_pkg::*;

  // Count compare width: wide enough for both the 5-bit count and DEPTH
  localparam int DepW = $clog2(DEPTH + 1);
  localparam int CntW = (DepW > OccW) ? DepW : OccW;

  logic [CapW-1:0]    capacity_q;
  logic [OccW-1:0]    count_q, count_d;
  logic               out_valid_q;
  logic [DataW-1:0]   out_value_q, out_value_d;
  logic [StatusW-1:0] out_status_q, out_status_d;
  logic [OccW-1:0]    out_occ_q;

  logic       accept;
  logic       is_full;
  logic       is_empty;
  ctrl_t      ctrl;

  logic [DataW-1:0] cell_data  [DEPTH];
  logic [DataW-1:0] left_data  [DEPTH];
  logic [DataW-1:0] right_data [DEPTH];
  logic [DataW-1:0] rear_data  [DEPTH];
  logic [DEPTH-1:0] cell_valid;
  logic [DEPTH-1:0] left_valid;
  logic [DEPTH-1:0] right_valid;
  logic [DataW-1:0] rear_word;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Full against the smaller of capacity and the physical row length
  assign is_full  = (CntW'(count_q) >= CntW'(capacity_q)) ||
                    (CntW'(count_q) >= CntW'(DEPTH));
  assign is_empty = (count_q == '0);

  // Neighbor wiring: cell 0 takes the pushed word from its left,
  // and the last cell sees an empty cell to its right
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) begin
        left_data[i]  = s_axis_tdata;
        left_valid[i] = 1'b1;
      end else begin
        left_data[i]  = cell_data[i-1];
        left_valid[i] = cell_valid[i-1];
      end
      if (i == DEPTH - 1) begin
        right_data[i]  = '0;
        right_valid[i] = 1'b0;
      end else begin
        right_data[i]  = cell_data[i+1];
        right_valid[i] = cell_valid[i+1];
      end
    end
  end

  // Only one cell is the rear, so OR the masked words together
  always_comb begin
    rear_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_word = rear_word | rear_data[i];
    end
  end

  // Decode the command, refuse on full or empty, build the result
  always_comb begin
    ctrl         = '0;
    count_d      = count_q;
    out_value_d  = '0;
    out_status_d = ST_DONE;
    unique case (s_axis_tuser) inside
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (is_full) begin
          out_status_d = ST_OVERFLOW;
        end else begin
          ctrl.shift_r  = accept && (s_axis_tuser == CMD_PUSH_FRONT);
          ctrl.put_rear = accept && (s_axis_tuser == CMD_PUSH_REAR);
          count_d       = count_q + OccW'(1);
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR: begin
        if (is_empty) begin
          out_status_d = ST_UNDERFLOW;
          out_value_d  = PopRefused;
        end else begin
          ctrl.shift_l   = accept && (s_axis_tuser == CMD_POP_FRONT);
          ctrl.drop_rear = accept && (s_axis_tuser == CMD_POP_REAR);
          out_value_d    = (s_axis_tuser == CMD_POP_FRONT) ? cell_data[0] : rear_word;
          count_d        = count_q - OccW'(1);
        end
      end
      default: begin
        out_status_d = ST_DONE;
      end
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    dqu_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .word_i        (s_axis_tdata),
      .left_data_i   (left_data[g]),
      .left_valid_i  (left_valid[g]),
      .right_data_i  (right_data[g]),
      .right_valid_i (right_valid[g]),
      .data_o        (cell_data[g]),
      .valid_o       (cell_valid[g]),
      .rear_data_o   (rear_data[g])
    );
  end

  // Control state: capacity, count, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= CapReset;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: load on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
      out_occ_q    <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_occ_q, out_value_q};
  assign m_axis_tuser  = out_status_q;

endmodule
`default_nettype wire

// ===== rtl/core/dqu_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dqu_cell
// One deque slot: a word and a valid bit, shifted to or from its neighbors.
// ----------------------------------------------------------------------------
module dqu_cell (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire dqu_pkg::ctrl_t            ctrl_i,
  input  wire logic [dqu_pkg::DataW-1:0] word_i,
  input  wire logic [dqu_pkg::DataW-1:0] left_data_i,
  input  wire logic                      left_valid_i,
  input  wire logic [dqu_pkg::DataW-1:0] right_data_i,
  input  wire logic                      right_valid_i,
  output logic      [dqu_pkg::DataW-1:0] data_o,
  output logic                           valid_o,
  output logic      [dqu_pkg::DataW-1:0] rear_data_o
);
  import dqu_pkg::*;

  logic [DataW-1:0] data_q, data_d;
  logic             valid_q, valid_d;
  logic             is_rear;

  assign is_rear = valid_q && !right_valid_i;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (ctrl_i.shift_r) begin
      data_d  = left_data_i;
      valid_d = left_valid_i;
    end else if (ctrl_i.shift_l) begin
      data_d  = right_data_i;
      valid_d = right_valid_i;
    end else if (ctrl_i.put_rear && !valid_q && left_valid_i) begin
      data_d  = word_i;
      valid_d = 1'b1;
    end else if (ctrl_i.drop_rear && is_rear) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o      = data_q;
  assign valid_o     = valid_q;
  assign rear_data_o = is_rear ? data_q : '0;

endmodule
`default_nettype wire
